@@ sv/sld_pkg.sv @@
// Shared constants, character codes and inter-module types for the scanner line deframer.
package sld_pkg;

	localparam int LINE_DEPTH = 64;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int MEM_AW     = ADDR_W + 1;
	localparam int MEM_DEPTH  = 2 * LINE_DEPTH;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 6;
	localparam int TDATA_W    = 16;
	localparam int PAD_W      = TDATA_W - BYTE_W - LEN_W;

	localparam logic [BYTE_W-1:0] CH_STX    = 8'h02;
	localparam logic [BYTE_W-1:0] CH_ETX    = 8'h03;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_LOW    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_HIGH   = 8'h7E;

	// One finished line waiting to be drained.
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
	} job_t;

	// Line store write request from the front end.
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [BYTE_W-1:0] data;
	} wr_req_t;

	// Back end hands a drained bank back to the front end.
	typedef struct packed {
		logic en;
		logic bank;
	} release_t;

endpackage

@@ sv/sld_front.sv @@
// Front end: accepts scanner bytes, classifies them, fills the line store, queues lines.
module sld_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,    // [7:0] rx_byte
	output sld_pkg::wr_req_t   wr,
	output logic               push,
	output sld_pkg::job_t      push_job,
	input  sld_pkg::release_t  rel
);

	logic                      bank_q;
	logic [1:0]                busy_q;
	logic [1:0]                busy_d;
	logic [sld_pkg::ADDR_W-1:0] fill_q;
	logic [sld_pkg::ADDR_W:0]  next_fill;
	logic                      accept;
	logic                      full;
	logic                      is_restart;
	logic                      is_term;
	logic                      is_print;

	// A bank still being drained cannot take new bytes.
	assign s_tready = !busy_q[bank_q];
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		next_fill  = (sld_pkg::ADDR_W+1)'(fill_q) + (sld_pkg::ADDR_W+1)'(1);
		full       = next_fill == (sld_pkg::ADDR_W+1)'(sld_pkg::LINE_DEPTH);
		is_restart = (s_tdata == sld_pkg::CH_STX) || (s_tdata == sld_pkg::CH_DOLLAR);
		is_term    = (s_tdata == sld_pkg::CH_LF) || (s_tdata == sld_pkg::CH_CR) ||
		             (s_tdata == sld_pkg::CH_TAB) || (s_tdata == sld_pkg::CH_ETX);
		is_print   = (s_tdata >= sld_pkg::CH_LOW) && (s_tdata <= sld_pkg::CH_HIGH);
	end

	// The released bank is never the one being filled, so both updates can land together.
	always_comb begin
		busy_d = busy_q;
		if (rel.en) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (push) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	// Every accepted byte lands at the fill position; bytes that are not kept are
	// simply overwritten by the next one.
	assign wr.en   = accept;
	assign wr.addr = {bank_q, fill_q};
	assign wr.data = s_tdata;

	// A kept line never ends in CR, so LF needs no special handling here.
	assign push          = accept && !full && is_term && (fill_q != '0);
	assign push_job.bank = bank_q;
	assign push_job.len  = sld_pkg::LEN_W'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			busy_q <= '0;
			fill_q <= '0;
		end else begin
			busy_q <= busy_d;
			if (push) begin
				bank_q <= !bank_q;
			end
			if (accept) begin
				if (full || is_restart || is_term) begin
					fill_q <= '0;
				end else if (is_print) begin
					fill_q <= next_fill[sld_pkg::ADDR_W-1:0];
				end
			end
		end
	end

	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rel.en |-> busy_q[rel.bank])
		else $error("release of a bank that is not busy");

endmodule

@@ sv/sld_job_fifo.sv @@
// Two-entry queue of finished lines between the front end and the back end.
module sld_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sld_pkg::job_t push_job,
	input  logic          pop,
	output logic          head_valid,
	output sld_pkg::job_t head
);

	sld_pkg::job_t entries_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign head_valid = count_q != 2'd0;
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2))
		else $error("line queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != 2'd0))
		else $error("line queue underflow");

endmodule

@@ sv/sld_back.sv @@
// Back end: holds the two-bank line store and drains finished lines onto the output stream.
module sld_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sld_pkg::wr_req_t             wr,
	input  logic                         head_valid,
	input  sld_pkg::job_t                head,
	output logic                         pop,
	output sld_pkg::release_t            rel,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sld_pkg::TDATA_W-1:0]  m_tdata,   // [7:0] line_byte, [13:8] line_length
	output logic                         m_tlast    // line_last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SHOW
	} state_t;

	logic [sld_pkg::BYTE_W-1:0]  mem_q [sld_pkg::MEM_DEPTH];
	logic [sld_pkg::BYTE_W-1:0]  rdata_q;
	state_t                      state_q;
	logic                        m_tvalid_q;
	logic                        bank_q;
	logic [sld_pkg::LEN_W-1:0]   len_q;
	logic [sld_pkg::ADDR_W-1:0]  idx_q;
	logic [sld_pkg::MEM_AW-1:0]  rd_addr;
	logic                        last;
	logic                        out_done;

	assign rd_addr  = {bank_q, idx_q};
	assign last     = (sld_pkg::LEN_W'(idx_q) + sld_pkg::LEN_W'(1)) == len_q;
	assign out_done = m_tvalid_q && m_tready;

	// The read port keeps reloading the current address, so the shown byte
	// stays put while the receiver stalls.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign rel.en   = out_done && last;
	assign rel.bank = bank_q;

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last;
	assign m_tdata  = {{sld_pkg::PAD_W{1'b0}}, len_q, rdata_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			bank_q     <= 1'b0;
			len_q      <= '0;
			idx_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						bank_q  <= head.bank;
						len_q   <= head.len;
						idx_q   <= '0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					m_tvalid_q <= 1'b1;
					state_q    <= ST_SHOW;
				end
				ST_SHOW: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + sld_pkg::ADDR_W'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fetch_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> !m_tvalid)
		else $error("next line byte shown without a read cycle");

endmodule

@@ sv/scanner_line_deframer_top.sv @@
// Top level of the scanner line deframer: front end, line queue and back end.
//
// Raw scanner bytes enter on the s_ stream, one byte per request. Printable bytes
// (0x20..0x7E) are collected into a line; STX or '$' restarts it, and LF, CR,
// TAB or ETX ends it without being kept. A non-empty line leaves on the m_
// stream one byte per request, each carrying the line length, with tlast on the
// final byte. A line that fills the store to its depth is dropped silently.
// The input takes one byte per cycle while the bank it fills is free. The line
// store has two banks, so one line can be drained while the next one is
// collected; input stalls from the moment a second line finishes until the older
// one has left. Each output byte goes through a store read (ST_FETCH) and a show
// (ST_SHOW), and each line is first popped from the queue in ST_IDLE; when the
// back end is idle, the first byte follows the accepted terminator through the
// queue count register, ST_IDLE and ST_FETCH. Reset clears the fill count, bank
// flags, queue and output valid; store contents need no clearing. A receiver stall
// holds the shown byte and only backs up into the input once both banks are full.
module scanner_line_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [7:0] line_byte, [13:8] line_length, [15:14] zero
	output logic        m_tlast     // line_last
);

	sld_pkg::wr_req_t  wr;
	sld_pkg::job_t     push_job;
	sld_pkg::job_t     head;
	sld_pkg::release_t rel;
	logic              push;
	logic              pop;
	logic              head_valid;

	sld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.wr       (wr),
		.push     (push),
		.push_job (push_job),
		.rel      (rel)
	);

	sld_job_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rel        (rel),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for scanner_line_deframer_top: directed and random byte streams.
module tb_top;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [sld_pkg::BYTE_W-1:0] data;
		logic [sld_pkg::LEN_W-1:0]  len;
		logic                       last;
	} line_beat_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	logic [sld_pkg::BYTE_W-1:0] line_img [sld_pkg::LINE_DEPTH];
	int unsigned       fill_cnt = 0;
	line_beat_t        pending_beats [$];
	int unsigned       fail_count = 0;
	int unsigned       cycle_count = 0;
	bit                idle_on = 1'b1;

	scanner_line_deframer_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void deliver_line();
		int unsigned n;
		n = fill_cnt;
		fill_cnt = 0;
		for (int unsigned i = 0; i < n; i++)
			pending_beats.push_back('{data: line_img[i], len: sld_pkg::LEN_W'(n),
				last: (i + 1 == n)});
	endfunction

	// Mirrors the framing rules: every byte is stored first, then the count is corrected.
	function automatic void frame_byte(input logic [sld_pkg::BYTE_W-1:0] c);
		if (fill_cnt >= sld_pkg::LINE_DEPTH)
			fill_cnt = 0;
		line_img[fill_cnt] = c;
		fill_cnt++;
		if (fill_cnt >= sld_pkg::LINE_DEPTH) begin
			fill_cnt = 0;
			return;
		end
		if (c == sld_pkg::CH_STX || c == sld_pkg::CH_DOLLAR) begin
			fill_cnt = 0;
		end else if (c == sld_pkg::CH_LF) begin
			if (fill_cnt >= 2 && line_img[fill_cnt - 2] == sld_pkg::CH_CR)
				fill_cnt -= 2;
			else
				fill_cnt -= 1;
			deliver_line();
		end else if (c == sld_pkg::CH_CR || c == sld_pkg::CH_TAB || c == sld_pkg::CH_ETX) begin
			fill_cnt -= 1;
			deliver_line();
		end else if (c < sld_pkg::CH_LOW || c > sld_pkg::CH_HIGH) begin
			fill_cnt -= 1;
		end
	endfunction

	task automatic push_rx(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		frame_byte(b);
	endtask

	function automatic logic [7:0] printable_char(input bit allow_restart);
		logic [7:0] c;
		do c = 8'($urandom_range(sld_pkg::CH_LOW, sld_pkg::CH_HIGH));
		while (!allow_restart && c == sld_pkg::CH_DOLLAR);
		return c;
	endfunction

	function automatic logic [7:0] unprintable_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c >= sld_pkg::CH_LOW && c <= sld_pkg::CH_HIGH);
		return c;
	endfunction

	function automatic logic [7:0] pick_terminator();
		case ($urandom_range(0, 3))
			0: return sld_pkg::CH_ETX;
			1: return sld_pkg::CH_TAB;
			2: return sld_pkg::CH_CR;
			default: return sld_pkg::CH_LF;
		endcase
	endfunction

	task automatic push_line(input int unsigned len, input logic [7:0] term);
		for (int unsigned i = 0; i < len; i++)
			push_rx(printable_char(1'b0));
		push_rx(term);
	endtask

	task automatic test_printable_edges();
		push_rx(sld_pkg::CH_LOW);
		push_rx(8'h00);
		push_rx(8'h1F);
		push_rx(sld_pkg::CH_HIGH);
		push_rx(8'h7F);
		push_rx(8'hFF);
		push_rx(8'h80);
		push_rx(sld_pkg::CH_ETX);
	endtask

	task automatic test_restart_marks();
		push_rx(8'h41);
		push_rx(8'h42);
		push_rx(sld_pkg::CH_STX);
		push_rx(8'h43);
		push_rx(sld_pkg::CH_DOLLAR);
		push_rx(8'h44);
		push_rx(sld_pkg::CH_TAB);
	endtask

	task automatic test_terminators();
		push_rx(sld_pkg::CH_CR);
		push_rx(8'h31);
		push_rx(sld_pkg::CH_CR);
		push_rx(sld_pkg::CH_LF);
		push_rx(8'h32);
		push_rx(8'h33);
		push_rx(sld_pkg::CH_LF);
		push_rx(sld_pkg::CH_ETX);
		push_rx(sld_pkg::CH_TAB);
	endtask

	// A line keeps at most LINE_DEPTH-2 bytes; any byte after LINE_DEPTH-1 held ones drops it.
	task automatic test_full_store();
		push_line(sld_pkg::LINE_DEPTH - 2, sld_pkg::CH_LF);
		push_line(sld_pkg::LINE_DEPTH - 1, sld_pkg::CH_CR);
		push_line(3, sld_pkg::CH_ETX);
	endtask

	task automatic test_random_lines(input int unsigned item_goal);
		int unsigned start_fill;
		int unsigned len;
		forever begin
			start_fill = 0;
			case ($urandom_range(0, 19))
				0: begin
					repeat ($urandom_range(1, 6)) begin
						push_rx(8'($urandom_range(0, 255)));
						start_fill++;
					end
				end
				1: begin
					len = $urandom_range(sld_pkg::LINE_DEPTH - 8, sld_pkg::LINE_DEPTH - 1);
					push_line(len, pick_terminator());
					start_fill = len + 1;
				end
				default: begin
					len = $urandom_range(0, 16);
					for (int unsigned i = 0; i < len; i++) begin
						case ($urandom_range(0, 15))
							0: push_rx(unprintable_char());
							1: push_rx(($urandom_range(0, 1) != 0) ?
								sld_pkg::CH_STX : sld_pkg::CH_DOLLAR);
							default: push_rx(printable_char(1'b0));
						endcase
					end
					if ($urandom_range(0, 4) == 0) begin
						push_rx(sld_pkg::CH_CR);
						push_rx(sld_pkg::CH_LF);
						start_fill = len + 2;
					end else begin
						push_rx(pick_terminator());
						start_fill = len + 1;
					end
				end
			endcase
			if (start_fill >= item_goal)
				break;
			item_goal -= start_fill;
		end
	endtask

	// Output side: random receiver stalls while idling is on.
	initial begin
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		line_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected line beat: got byte %h len %0d last %b",
					$time, m_tdata[7:0], m_tdata[13:8], m_tlast);
				fail_count++;
			end else begin
				want = pending_beats.pop_front();
				if (m_tdata[7:0] !== want.data || m_tdata[13:8] !== want.len ||
						m_tlast !== want.last || m_tdata[15:14] !== 2'b00) begin
					$display("%0t: beat mismatch: expected %h/%0d/%b, got %h/%0d/%b pad %b",
						$time, want.data, want.len, want.last,
						m_tdata[7:0], m_tdata[13:8], m_tlast, m_tdata[15:14]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("scanner_line_deframer_top verification failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_printable_edges();
		test_restart_marks();
		test_terminators();
		test_full_store();
		test_random_lines(70);
		idle_on = 1'b0;
		test_random_lines(25);
		s_tvalid <= 1'b0;
		wait (pending_beats.size() == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("scanner_line_deframer_top verification clean");
		else
			$display("scanner_line_deframer_top verification failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/sld_pkg.sv
sv/sld_front.sv
sv/sld_job_fifo.sv
sv/sld_back.sv
sv/scanner_line_deframer_top.sv
test/tb_top.sv
